// File: hdl/mexp_pkg.sv
package mexp_pkg;

    // Width of the modulus, the exponent and the base inside the core.
    localparam int MOD_W = 32;
    // Width of the payload and configuration ports.
    localparam int DATA_W = 32;
    // Width of the bit counter of the modular multiplier.
    localparam int CNT_W = $clog2(MOD_W);
    // Width of the configuration register index.
    localparam int CFG_IDX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [MOD_W-1:0] MODULUS_RST  = MOD_W'(2);
    localparam logic [MOD_W-1:0] EXPONENT_RST = MOD_W'(1);

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_GO,
        ST_RED_WAIT,
        ST_BIT,
        ST_ACC_WAIT,
        ST_SQ_WAIT,
        ST_FINISH
    } state_t;

    // Operand selection for the modular multiplier.
    typedef enum logic [1:0] {
        OP_REDUCE,
        OP_ACC,
        OP_SQ
    } mul_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_base;
        logic    mul_start;
        mul_op_t mul_op;
        logic    cap_acc;
        logic    cap_sq;
        logic    shift_exp;
        logic    load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mul_done;
        logic exp_bit;
        logic exp_zero;
        logic out_busy;
    } dp_status_t;

endpackage

// File: hdl/mexp_modmul.sv
module mexp_modmul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [mexp_pkg::MOD_W-1:0]    op_a,
    input  logic [mexp_pkg::MOD_W-1:0]    op_y,
    input  logic [mexp_pkg::MOD_W-1:0]    modulus,
    output logic                          done,
    output logic [mexp_pkg::MOD_W-1:0]    product
);

    logic [mexp_pkg::MOD_W-1:0] a_reg;
    logic [mexp_pkg::MOD_W-1:0] a_next;
    logic [mexp_pkg::MOD_W-1:0] y_reg;
    logic [mexp_pkg::MOD_W-1:0] y_next;
    logic [mexp_pkg::MOD_W-1:0] r_reg;
    logic [mexp_pkg::MOD_W-1:0] r_next;
    logic [mexp_pkg::CNT_W-1:0] cnt_reg;
    logic [mexp_pkg::CNT_W-1:0] cnt_next;
    logic                       busy_reg;
    logic                       busy_next;
    logic                       done_reg;
    logic                       done_next;

    logic [mexp_pkg::MOD_W+1:0] sum;
    logic [mexp_pkg::MOD_W+1:0] mod1;
    logic [mexp_pkg::MOD_W+1:0] mod2;
    logic [mexp_pkg::MOD_W+1:0] sub1;
    logic [mexp_pkg::MOD_W+1:0] sub2;
    logic [mexp_pkg::MOD_W-1:0] step_r;

    // One multiplier bit per cycle, most significant first: r = 2r + bit*y, then
    // reduce. With r and y below the modulus the sum stays below three moduli.
    assign mod1 = (mexp_pkg::MOD_W+2)'(modulus);
    assign mod2 = {1'b0, modulus, 1'b0};
    assign sum  = {1'b0, r_reg, 1'b0}
                + (a_reg[mexp_pkg::MOD_W-1] ? (mexp_pkg::MOD_W+2)'(y_reg) : '0);
    assign sub1 = sum - mod1;
    assign sub2 = sum - mod2;

    always_comb begin
        if (sum >= mod2) begin
            step_r = sub2[mexp_pkg::MOD_W-1:0];
        end else if (sum >= mod1) begin
            step_r = sub1[mexp_pkg::MOD_W-1:0];
        end else begin
            step_r = sum[mexp_pkg::MOD_W-1:0];
        end
    end

    // Sequencing of one multiplication.
    always_comb begin
        a_next    = a_reg;
        y_next    = y_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            a_next    = op_a;
            y_next    = op_y;
            r_next    = '0;
            cnt_next  = mexp_pkg::CNT_W'(mexp_pkg::MOD_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            a_next   = {a_reg[mexp_pkg::MOD_W-2:0], 1'b0};
            r_next   = step_r;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        a_reg   <= a_next;
        y_reg   <= y_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
    end

    assign done    = done_reg;
    assign product = r_reg;

`ifndef NO_ASSERTIONS
    // A new multiplication is only started while the unit is free.
    assert property (@(posedge aclk) disable iff (!aresetn) start |-> !busy_reg)
        else $error("modmul started while busy");

    // Completion is flagged only after the iteration has stopped.
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> !busy_reg)
        else $error("modmul done while still busy");

    // A finished product is always a residue of a nonzero modulus.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && modulus != '0) |-> (r_reg < modulus))
        else $error("modmul product not reduced");
`endif

endmodule

// File: hdl/mexp_datapath.sv
module mexp_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mexp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mexp_pkg::DATA_W-1:0]       cfg_wdata,
    input  logic [mexp_pkg::DATA_W-1:0]       s_base,
    output logic [mexp_pkg::DATA_W-1:0]       m_power_mod,
    output logic                              m_valid,
    input  logic                              m_ready,
    input  mexp_pkg::ctrl_cmd_t               cmd,
    output mexp_pkg::dp_status_t              status
);

    logic [mexp_pkg::MOD_W-1:0] modulus_reg;
    logic [mexp_pkg::MOD_W-1:0] exponent_reg;
    logic [mexp_pkg::MOD_W-1:0] acc_reg;
    logic [mexp_pkg::MOD_W-1:0] sq_reg;
    logic [mexp_pkg::MOD_W-1:0] exp_reg;
    logic [mexp_pkg::MOD_W-1:0] result_reg;
    logic                       out_valid_reg;

    logic [mexp_pkg::MOD_W-1:0] op_a;
    logic [mexp_pkg::MOD_W-1:0] op_y;
    logic                       mul_done;
    logic [mexp_pkg::MOD_W-1:0] product;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= mexp_pkg::MODULUS_RST;
            exponent_reg <= mexp_pkg::EXPONENT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                mexp_pkg::REG_MODULUS: begin
                    modulus_reg <= cfg_wdata[mexp_pkg::MOD_W-1:0];
                end
                mexp_pkg::REG_EXPONENT: begin
                    exponent_reg <= cfg_wdata[mexp_pkg::MOD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (cmd.mul_op)
            mexp_pkg::OP_REDUCE: begin
                op_a = sq_reg;
                op_y = mexp_pkg::MOD_W'(1);
            end
            mexp_pkg::OP_ACC: begin
                op_a = acc_reg;
                op_y = sq_reg;
            end
            mexp_pkg::OP_SQ: begin
                op_a = sq_reg;
                op_y = sq_reg;
            end
            default: begin
                op_a = sq_reg;
                op_y = sq_reg;
            end
        endcase
    end

    mexp_modmul u_modmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .op_a    (op_a),
        .op_y    (op_y),
        .modulus (modulus_reg),
        .done    (mul_done),
        .product (product)
    );

    // Working registers: running product, repeated square and exponent bits.
    always_ff @(posedge aclk) begin
        if (cmd.load_base) begin
            sq_reg  <= s_base[mexp_pkg::MOD_W-1:0];
            acc_reg <= (modulus_reg == mexp_pkg::MOD_W'(1)) ? '0 : mexp_pkg::MOD_W'(1);
            exp_reg <= exponent_reg;
        end else begin
            if (cmd.cap_acc) begin
                acc_reg <= product;
            end
            if (cmd.cap_sq) begin
                sq_reg <= product;
            end
            if (cmd.shift_exp) begin
                exp_reg <= exp_reg >> 1;
            end
        end
    end

    // Output register; a zero modulus has no residue and reports zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            result_reg <= (modulus_reg == '0) ? '0 : acc_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_power_mod = mexp_pkg::DATA_W'(result_reg);

    assign status.mul_done = mul_done;
    assign status.exp_bit  = exp_reg[0];
    assign status.exp_zero = (exp_reg == '0);
    assign status.out_busy = out_valid_reg && !m_ready;

endmodule

// File: hdl/mexp_ctrl.sv
module mexp_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mexp_pkg::dp_status_t  status,
    output mexp_pkg::ctrl_cmd_t   cmd
);

    mexp_pkg::state_t state_reg;
    mexp_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mexp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mul_op    = mexp_pkg::OP_SQ;
        s_ready       = 1'b0;
        case (state_reg)
            mexp_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_base = 1'b1;
                    state_next    = mexp_pkg::ST_RED_GO;
                end
            end
            mexp_pkg::ST_RED_GO: begin
                // Reduce the base modulo the modulus by multiplying it by one.
                cmd.mul_start = 1'b1;
                cmd.mul_op    = mexp_pkg::OP_REDUCE;
                state_next    = mexp_pkg::ST_RED_WAIT;
            end
            mexp_pkg::ST_RED_WAIT: begin
                if (status.mul_done) begin
                    cmd.cap_sq = 1'b1;
                    state_next = mexp_pkg::ST_BIT;
                end
            end
            mexp_pkg::ST_BIT: begin
                // Stop once no set exponent bit is left.
                if (status.exp_zero) begin
                    state_next = mexp_pkg::ST_FINISH;
                end else if (status.exp_bit) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = mexp_pkg::OP_ACC;
                    state_next    = mexp_pkg::ST_ACC_WAIT;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = mexp_pkg::OP_SQ;
                    state_next    = mexp_pkg::ST_SQ_WAIT;
                end
            end
            mexp_pkg::ST_ACC_WAIT: begin
                if (status.mul_done) begin
                    cmd.cap_acc   = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = mexp_pkg::OP_SQ;
                    state_next    = mexp_pkg::ST_SQ_WAIT;
                end
            end
            mexp_pkg::ST_SQ_WAIT: begin
                if (status.mul_done) begin
                    cmd.cap_sq    = 1'b1;
                    cmd.shift_exp = 1'b1;
                    state_next    = mexp_pkg::ST_BIT;
                end
            end
            mexp_pkg::ST_FINISH: begin
                // Hand the result over once the output register is free.
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = mexp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/modular_exponentiation_top.sv
// Channel    Direction  Handshake           Payload
// s_         in         s_valid / s_ready   s_base (32 bits, unsigned)
// m_         out        m_valid / m_ready   m_power_mod (32 bits, unsigned)
// cfg_       in         cfg_we              cfg_index, cfg_wdata
//
// One transaction at a time. When a multiply and a squaring are chained, the squaring starts in the cycle
// the multiply completes. An item first reduces the base, then for each exponent bit up to the highest
// set one squares, multiplying into the running product first when the bit is set, and then finishes.
// Reset is synchronous and active low; modulus resets to 2 and exponent to 1.
// A finished result waits in the output register and the next transaction is accepted
// while it waits; a stalled output stalls the core only at completion.
module modular_exponentiation_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [mexp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mexp_pkg::DATA_W-1:0]       cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mexp_pkg::DATA_W-1:0]       s_base,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [mexp_pkg::DATA_W-1:0]       m_power_mod
);

    mexp_pkg::ctrl_cmd_t  cmd;
    mexp_pkg::dp_status_t status;

    mexp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mexp_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_base      (s_base),
        .m_power_mod (m_power_mod),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// File: sim/mexp_checker.sv
module mexp_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [mexp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mexp_pkg::DATA_W-1:0]         cfg_wdata,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [mexp_pkg::DATA_W-1:0]         s_base,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic [mexp_pkg::DATA_W-1:0]         m_power_mod,
    output int unsigned                         fail_cnt,
    output int unsigned                         pending_cnt,
    output int unsigned                         results_cnt
);

    timeunit 1ns;
    timeprecision 1ps;

    // One outstanding result together with the base that caused it.
    typedef struct packed {
        logic [mexp_pkg::DATA_W-1:0] base;
        logic [mexp_pkg::DATA_W-1:0] power_mod;
    } power_mod_entry_t;

    // Shadow copies of the configuration registers.
    logic [mexp_pkg::MOD_W-1:0]  shadow_modulus;
    logic [mexp_pkg::MOD_W-1:0]  shadow_exponent;
    power_mod_entry_t            pending_power_mod[$];
    power_mod_entry_t            oldest;
    power_mod_entry_t            fresh;
    int unsigned                 mismatch_total;
    int unsigned                 result_total;

    // Square-and-multiply over the exponent bits, LSB first.
    function automatic logic [mexp_pkg::DATA_W-1:0] calc_power_mod(
        input logic [mexp_pkg::MOD_W-1:0] base,
        input logic [mexp_pkg::MOD_W-1:0] exponent,
        input logic [mexp_pkg::MOD_W-1:0] modulus
    );
        logic [63:0]                acc;
        logic [63:0]                sq;
        logic [mexp_pkg::MOD_W-1:0] rest;
        if (modulus == '0) begin
            return '0;
        end
        acc  = 64'd1 % modulus;
        sq   = 64'(base) % modulus;
        rest = exponent;
        while (rest != '0) begin
            if (rest[0]) begin
                acc = (acc * sq) % modulus;
            end
            sq   = (sq * sq) % modulus;
            rest = rest >> 1;
        end
        return mexp_pkg::DATA_W'(acc);
    endfunction

    // Track register writes, predict on input transactions, compare on output ones.
    always @(posedge aclk) begin
        if (!aresetn) begin
            shadow_modulus  = mexp_pkg::MODULUS_RST;
            shadow_exponent = mexp_pkg::EXPONENT_RST;
            pending_power_mod.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    mexp_pkg::REG_MODULUS:  shadow_modulus  = mexp_pkg::MOD_W'(cfg_wdata);
                    mexp_pkg::REG_EXPONENT: shadow_exponent = mexp_pkg::MOD_W'(cfg_wdata);
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                fresh.base      = s_base;
                fresh.power_mod = calc_power_mod(mexp_pkg::MOD_W'(s_base), shadow_exponent,
                                                 shadow_modulus);
                pending_power_mod.push_back(fresh);
            end

            if (m_valid && m_ready) begin
                result_total++;
                if (pending_power_mod.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10) begin
                        $display("[%0t] unexpected result: power_mod %h with nothing pending",
                                 $time, m_power_mod);
                    end
                end else begin
                    oldest = pending_power_mod.pop_front();
                    if (m_power_mod !== oldest.power_mod) begin
                        mismatch_total++;
                        if (mismatch_total <= 10) begin
                            $display("[%0t] power_mod mismatch: base %h expected %h actual %h",
                                     $time, oldest.base, oldest.power_mod, m_power_mod);
                        end
                    end
                end
            end
        end
        fail_cnt    <= mismatch_total;
        pending_cnt <= pending_power_mod.size();
        results_cnt <= result_total;
    end

endmodule

// File: sim/tb_top.sv
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TOTAL_ITEMS  = 290;
    localparam int unsigned QUIET_FROM   = 245;
    localparam int unsigned HOLD_CYCLES  = 6000;
    localparam int unsigned DRAIN_CYCLES = 2400;
    localparam int unsigned CYCLE_LIMIT  = 4000000;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [mexp_pkg::CFG_IDX_W-1:0] cfg_index = mexp_pkg::REG_MODULUS;
    logic [mexp_pkg::DATA_W-1:0]    cfg_wdata = '0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [mexp_pkg::DATA_W-1:0]    s_base = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [mexp_pkg::DATA_W-1:0]    m_power_mod;

    int unsigned fail_cnt;
    int unsigned pending_cnt;
    int unsigned results_cnt;

    // Shared state of the stimulus, receiver and watchdog processes.
    bit          bursty = 1'b1;
    bit          hold_req = 1'b0;
    int unsigned bases_sent = 0;
    int unsigned settings_used = 0;
    int unsigned cycle_cnt = 0;

    modular_exponentiation_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_base      (s_base),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_power_mod (m_power_mod)
    );

    mexp_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_base      (s_base),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_power_mod (m_power_mod),
        .fail_cnt    (fail_cnt),
        .pending_cnt (pending_cnt),
        .results_cnt (results_cnt)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Offer one base and wait for its transaction, then maybe leave a gap.
    task automatic send_base(input logic [mexp_pkg::DATA_W-1:0] base);
        int unsigned gap;
        gap = 0;
        if (bursty && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 12);
        end
        s_valid <= 1'b1;
        s_base  <= base;
        do @(posedge aclk); while (!s_ready);
        bases_sent++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop offering and wait until every result of the accepted bases is back.
    task automatic wait_results;
        s_valid <= 1'b0;
        while (results_cnt < bases_sent) @(posedge aclk);
    endtask

    // Write both registers on consecutive cycles; only called while idle.
    task automatic set_config(input logic [mexp_pkg::DATA_W-1:0] modulus,
                              input logic [mexp_pkg::DATA_W-1:0] exponent);
        cfg_we    <= 1'b1;
        cfg_index <= mexp_pkg::REG_MODULUS;
        cfg_wdata <= modulus;
        @(posedge aclk);
        cfg_index <= mexp_pkg::REG_EXPONENT;
        cfg_wdata <= exponent;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [mexp_pkg::DATA_W-1:0] pick_modulus();
        case ($urandom_range(0, 9))
            0:       return 32'hFFFF_FFFF;
            1:       return $urandom_range(2, 255);
            2:       return $urandom_range(256, 65535);
            7:       return $urandom();
            8:       return $urandom_range(0, 1);
            9:       return 32'd2;
            default: return $urandom() | 32'h8000_0000;
        endcase
    endfunction

    // Mostly short exponents keep the run fast; some use all 32 bits.
    function automatic logic [mexp_pkg::DATA_W-1:0] pick_exponent();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'd3;
            3:       return 32'd65537;
            6:       return $urandom();
            7:       return $urandom() | 32'h8000_0000;
            default: return $urandom_range(2, 1023);
        endcase
    endfunction

    function automatic logic [mexp_pkg::DATA_W-1:0] pick_base(
        input logic [mexp_pkg::DATA_W-1:0] modulus
    );
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 32'd1;
            2:       return 32'hFFFF_FFFF;
            3:       return modulus - 32'd1;
            4:       return modulus;
            default: return $urandom();
        endcase
    endfunction

    // Receiver: random ready bursts, one long hold-off on request, steady at the end.
    initial begin
        int unsigned burst;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
                hold_req = 1'b0;
            end else if (!bursty) begin
                m_ready <= 1'b1;
            end else begin
                burst = $urandom_range(1, 12);
                m_ready <= ($urandom_range(0, 2) != 0);
                repeat (burst - 1) @(posedge aclk);
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Timeout after %0d cycles", cycle_cnt);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        int unsigned                 batch;
        logic [mexp_pkg::DATA_W-1:0] modulus;
        logic [mexp_pkg::DATA_W-1:0] exponent;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: modulus 2, exponent 1.
        send_base(32'd0);
        send_base(32'd1);
        send_base(32'hFFFF_FFFF);
        wait_results();

        // Widest modulus with a full-width exponent.
        set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_base(32'd0);
        send_base(32'd1);
        send_base(32'hFFFF_FFFE);
        send_base(32'hFFFF_FFFF);
        wait_results();

        // Modulus of one gives zero for every base.
        set_config(32'd1, 32'd65537);
        send_base(32'd5);
        send_base(32'hFFFF_FFFF);
        wait_results();

        // Modulus of zero has no residue.
        set_config(32'd0, 32'd3);
        send_base(32'd7);
        send_base(32'hFFFF_FFFF);
        wait_results();

        // Zero exponent yields one, or zero under a modulus of one.
        set_config(32'd3233, 32'd0);
        send_base(32'd0);
        send_base(32'd65);
        send_base(32'hFFFF_FFFF);
        wait_results();
        set_config(32'd1, 32'd0);
        send_base(32'd9);
        wait_results();

        // Textbook key pair: encrypt with the public exponent, decrypt with the private.
        set_config(32'd3233, 32'd17);
        send_base(32'd65);
        send_base(32'hDEAD_BEEF);
        wait_results();
        set_config(32'd3233, 32'd2753);
        send_base(32'd2790);
        wait_results();

        // Smallest modulus with only the top exponent bit set.
        set_config(32'd2, 32'h8000_0000);
        send_base(32'd3);
        wait_results();

        // Squaring the largest residue of a large modulus.
        set_config(32'hFFFF_FFFB, 32'd2);
        send_base(32'hFFFF_FFFA);
        wait_results();

        // Long output stall while bases keep coming, so the input backs up.
        modulus = $urandom() | 32'h8000_0001;
        set_config(modulus, 32'd65537);
        hold_req = 1'b1;
        repeat (6) send_base(pick_base(modulus));
        wait_results();

        // Random settings, each followed by a batch of random bases.
        while (bases_sent < TOTAL_ITEMS) begin
            if (bases_sent >= QUIET_FROM) begin
                bursty = 1'b0;
            end
            batch = $urandom_range(4, 16);
            if (batch > TOTAL_ITEMS - bases_sent) begin
                batch = TOTAL_ITEMS - bases_sent;
            end
            modulus  = pick_modulus();
            exponent = pick_exponent();
            set_config(modulus, exponent);
            repeat (batch) send_base(pick_base(modulus));
            wait_results();
        end

        // Give the block time to show any stray result.
        bursty = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d bases over %0d register settings, %0d results checked.",
                 bases_sent, settings_used, results_cnt);
        $display("Moduli 0, 1, 2 and all ones, zero and full-width exponents, one long stall.");
        if (pending_cnt != 0) begin
            $display("%0d expected results never arrived", pending_cnt);
        end
        if (fail_cnt == 0 && pending_cnt == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches", fail_cnt);
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/mexp_pkg.sv
hdl/mexp_modmul.sv
hdl/mexp_datapath.sv
hdl/mexp_ctrl.sv
hdl/modular_exponentiation_top.sv
sim/mexp_checker.sv
sim/tb_top.sv
